// ----- rtl/mfs_pkg.sv -----
// mfs_pkg: widths, field positions, descriptor type for the fragment splitter
// no dependencies; used by every module of the splitter
`timescale 1ns / 1ps
package mfs_pkg;

  localparam int HEADER_BYTES  = 20;
  localparam int MAX_FRAGMENTS = 64;

  localparam int LEN_W  = 32;
  localparam int MFB_W  = 16;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int PAY_W  = MFB_W + CNT_W;
  localparam int STEP_W = $clog2(CNT_W);

  localparam logic [MFB_W-1:0] MFB_RESET = 16'd4096;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_W   = 96;
  localparam int OUT_W  = 144;
  localparam int USER_W = 2;

  localparam int OFF_TYPE   = 0;
  localparam int OFF_LEN    = 32;
  localparam int OFF_TID    = 48;
  localparam int OFF_TOTAL  = 80;
  localparam int OFF_INDEX  = 87;
  localparam int OFF_OFFSET = 93;
  localparam int OFF_PBYTES = 125;
  localparam int OUT_PAD    = OUT_W - (OFF_PBYTES + MFB_W);

  localparam int USER_UNSPLIT  = 0;
  localparam int USER_TOO_MANY = 1;

  typedef enum logic [1:0] {
    KIND_UNSPLIT,
    KIND_TOO_MANY,
    KIND_SPLIT
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [LEN_W-1:0]   msg_type;
    logic [LEN_W-1:0]   tid;
    logic [MFB_W-1:0]   len;
    logic [PAY_W-1:0]   payload;
    logic [MFB_W-1:0]   per;
    logic [CNT_W-1:0]   count;
  } desc_t;

endpackage

// ----- rtl/message_fragment_splitter_top.sv -----
// message_fragment_splitter_top: control message fragment header generator
// depends on mfs_pkg, mfs_front, mfs_queue, mfs_back
//
// channel  direction  tdata (low bit first)                          tuser / tlast
// s_*      in         message_length, msg_type, trans_id             -
// m_*      out        frag_type, frag_length, frag_transaction,      unsplit, too_many /
//                     fragment_total, fragment_index,                last
//                     payload_offset, payload_bytes
// cfg_*    in         max_fragment_bytes                             -
//
// front: F_IDLE accepts, F_CLASS classifies, F_DIV runs a restoring division for split messages,
//   then F_PUSH hands the descriptor to a 2-entry queue
// back: B_IDLE loads a descriptor, then B_RUN gives one result per cycle while m_tready is high
// rst is synchronous; max_fragment_bytes resets to 4096
// the front stalls only on a full queue, the back only on m_tready
`timescale 1ns / 1ps
module message_fragment_splitter_top
  import mfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [MFB_W-1:0]  cfg_wr_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // message_length, msg_type, trans_id
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // frag_type, frag_length, frag_transaction,
                                       // fragment_total, fragment_index,
                                       // payload_offset, payload_bytes, zero pad
  output logic [USER_W-1:0] m_tuser,   // unsplit, too_many
  output logic              m_tlast
);

  desc_t push_desc;
  desc_t pop_desc;
  logic  push;
  logic  full;
  logic  pop;
  logic  empty;

  mfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .push        (push),
    .push_desc   (push_desc),
    .full        (full)
  );

  mfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .empty     (empty)
  );

  mfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_desc (pop_desc),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- rtl/mfs_front.sv -----
// mfs_front: accepts descriptors, classifies them, divides out the fragment count
// depends on mfs_pkg; feeds mfs_queue
`timescale 1ns / 1ps
module mfs_front
  import mfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [MFB_W-1:0] cfg_wr_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             push,
  output desc_t            push_desc,
  input  logic             full
);

  typedef enum logic [1:0] {F_IDLE, F_CLASS, F_DIV, F_PUSH} fstate_t;

  fstate_t            state;
  logic [MFB_W-1:0]   mfb;
  logic [LEN_W-1:0]   len_r;
  desc_t              desc_r;
  logic [PAY_W-1:0]   rem;
  logic [CNT_W-1:0]   quo;
  logic [STEP_W-1:0]  step;

  logic [LEN_W-1:0]   payload_full;
  logic [MFB_W-1:0]   per_c;
  logic [PAY_W-1:0]   limit;
  logic [PAY_W-1:0]   divisor_sh;
  logic               fits;
  logic               no_room;
  logic               over_limit;

  assign payload_full = len_r - LEN_W'(HEADER_BYTES);
  assign per_c        = mfb - MFB_W'(HEADER_BYTES);
  assign limit        = PAY_W'(per_c) * PAY_W'(MAX_FRAGMENTS);
  assign fits         = len_r <= LEN_W'(mfb);
  assign no_room      = mfb <= MFB_W'(HEADER_BYTES);
  assign over_limit   = payload_full > LEN_W'(limit);
  assign divisor_sh   = PAY_W'(desc_r.per) << step;

  assign s_tready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && !full;

  always_comb begin
    push_desc       = desc_r;
    push_desc.count = quo + CNT_W'(rem != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      mfb   <= MFB_RESET;
    end else begin
      if (cfg_wr_en) begin
        mfb <= cfg_wr_data;
      end
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            len_r           <= s_tdata[LEN_W-1:0];
            desc_r.msg_type <= s_tdata[2*LEN_W-1:LEN_W];
            desc_r.tid      <= s_tdata[3*LEN_W-1:2*LEN_W];
            state           <= F_CLASS;
          end
        end
        F_CLASS: begin
          desc_r.len     <= len_r[MFB_W-1:0];
          desc_r.per     <= per_c;
          desc_r.payload <= payload_full[PAY_W-1:0];
          desc_r.count   <= '0;
          quo            <= '0;
          rem            <= '0;
          if (fits) begin
            desc_r.kind <= KIND_UNSPLIT;
            state       <= F_PUSH;
          end else if (no_room || over_limit) begin
            desc_r.kind <= KIND_TOO_MANY;
            state       <= F_PUSH;
          end else begin
            desc_r.kind <= KIND_SPLIT;
            rem         <= payload_full[PAY_W-1:0];
            step        <= STEP_W'(CNT_W - 1);
            state       <= F_DIV;
          end
        end
        F_DIV: begin
          if (rem >= divisor_sh) begin
            rem       <= rem - divisor_sh;
            quo[step] <= 1'b1;
          end
          if (step == '0) begin
            state <= F_PUSH;
          end else begin
            step <= step - 1'b1;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/mfs_queue.sv -----
// mfs_queue: short descriptor queue between front and back
// depends on mfs_pkg
`timescale 1ns / 1ps
module mfs_queue
  import mfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output desc_t pop_desc,
  output logic  empty
);

  desc_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_desc = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mfs_back.sv -----
// mfs_back: walks a descriptor and emits one fragment header per cycle while m_tready does not stall it
// depends on mfs_pkg; drains mfs_queue
`timescale 1ns / 1ps
module mfs_back
  import mfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  desc_t             pop_desc,
  input  logic              empty,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic [USER_W-1:0] m_tuser,
  output logic              m_tlast
);

  typedef enum logic {B_IDLE, B_RUN} bstate_t;

  bstate_t           state;
  desc_t             cur;
  logic [PAY_W-1:0]  rem;
  logic [PAY_W-1:0]  offset;
  logic [IDX_W-1:0]  idx;

  logic              out_free;
  logic [MFB_W-1:0]  chunk;
  logic              last_frag;
  logic [OUT_W-1:0]  out_data;
  logic [USER_W-1:0] out_user;
  logic              out_last;

  assign out_free  = !m_tvalid || m_tready;
  assign pop       = (state == B_IDLE) && !empty;
  assign chunk     = (rem > PAY_W'(cur.per)) ? cur.per : rem[MFB_W-1:0];
  assign last_frag = (CNT_W'(idx) + 1'b1) == cur.count;

  always_comb begin
    out_data = '0;
    out_user = '0;
    out_last = 1'b1;
    out_data[OFF_TYPE +: LEN_W] = cur.msg_type;
    out_data[OFF_TID +: LEN_W]  = cur.tid;
    case (cur.kind)
      KIND_UNSPLIT: begin
        out_data[OFF_LEN +: MFB_W] = cur.len;
        out_user[USER_UNSPLIT]     = 1'b1;
      end
      KIND_SPLIT: begin
        out_data[OFF_LEN +: MFB_W]    = chunk + MFB_W'(HEADER_BYTES);
        out_data[OFF_TOTAL +: CNT_W]  = cur.count;
        out_data[OFF_INDEX +: IDX_W]  = idx;
        out_data[OFF_OFFSET +: LEN_W] = LEN_W'(offset);
        out_data[OFF_PBYTES +: MFB_W] = chunk;
        out_last                      = last_frag;
      end
      default: begin
        out_user[USER_TOO_MANY] = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != B_RUN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            cur    <= pop_desc;
            rem    <= pop_desc.payload;
            offset <= '0;
            idx    <= '0;
            state  <= B_RUN;
          end
        end
        B_RUN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= out_data;
            m_tuser  <= out_user;
            m_tlast  <= out_last;
            rem      <= rem - PAY_W'(chunk);
            offset   <= offset + PAY_W'(chunk);
            idx      <= idx + 1'b1;
            if (out_last) begin
              state <= B_IDLE;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/mfs_checker.sv -----
// mfs_checker: port-level checks on the splitter's result stream
// depends on mfs_pkg; bound to message_fragment_splitter_top
`timescale 1ns / 1ps
module mfs_checker
  import mfs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata,
  input logic [USER_W-1:0] m_tuser,
  input logic              m_tlast
);

  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] index_next;

  assign total      = m_tdata[OFF_TOTAL +: CNT_W];
  assign index_next = CNT_W'(m_tdata[OFF_INDEX +: IDX_W]) + 1'b1;

  // stalled transfer stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_unsplit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_UNSPLIT] |-> m_tlast && total == '0 && !m_tuser[USER_TOO_MANY])
    else $error("unsplit result malformed");

  a_too_many: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_TOO_MANY] |-> m_tlast && total == '0)
    else $error("too_many result malformed");

  // last fragment's index plus one matches the total, earlier ones stay below it
  a_frag_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == '0 |-> (m_tlast ? index_next == total : index_next < total))
    else $error("fragment index out of step with total");

endmodule

bind message_fragment_splitter_top mfs_checker u_mfs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
